FILE: src/msrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msrb_pkg - shared definitions for the multi-slot receive ring buffer
// Field widths, operation and status codes, register indexes, the controller
// state type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package msrb_pkg;

  // default configuration of the top level
  localparam int DEF_SLOTS    = 2;
  localparam int DEF_CAPACITY = 512;
  localparam int DEF_MAX_READ = 64;

  // fixed field widths
  localparam int OPC_W      = 2;
  localparam int BUS_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 7;
  localparam int FILL_OUT_W = 9;
  localparam int LOST_W     = 32;
  localparam int STAT_W     = 2;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;

  // configuration registers
  localparam int NUM_CFG_REGS = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_BUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_BUS = 1'b1;
  localparam logic [CFG_W-1:0]     BUS_FREE      = 4'b1111;

  // operations
  localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_ISSUE,
    ST_RD_LOAD,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic capture;   // take the input beat into the item registers
    logic exec;      // carry out the item against the selected ring
    logic rd_issue;  // start a memory read at the read pointer
    logic rd_load;   // move the read byte into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic drop_item;     // opcode without meaning, no result
    logic read_run;      // read with at least one byte to drain
    logic remaining_nz;  // bytes of the run still to go
    logic out_taken;     // output beat taken this cycle
  } dp_status_t;

endpackage : msrb_pkg
`default_nettype wire

FILE: src/msrb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msrb_ram - generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module msrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : msrb_ram
`default_nettype wire

FILE: src/msrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msrb_ctrl - item sequencer
// Takes one item at a time, runs it, and steps a read through its bytes.
// ----------------------------------------------------------------------------
module msrb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire msrb_pkg::dp_status_t  sts,
  output      msrb_pkg::ctrl_cmd_t   cmd,
  output      logic                  in_stall
);

  msrb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      msrb_pkg::ST_IDLE: begin
        if (in_valid) state_next = msrb_pkg::ST_EXEC;
      end
      msrb_pkg::ST_EXEC: begin
        if (sts.drop_item)     state_next = msrb_pkg::ST_IDLE;
        else if (sts.read_run) state_next = msrb_pkg::ST_RD_ISSUE;
        else                   state_next = msrb_pkg::ST_WAIT;
      end
      msrb_pkg::ST_RD_ISSUE: state_next = msrb_pkg::ST_RD_LOAD;
      msrb_pkg::ST_RD_LOAD:  state_next = msrb_pkg::ST_WAIT;
      msrb_pkg::ST_WAIT: begin
        if (sts.out_taken) begin
          state_next = sts.remaining_nz ? msrb_pkg::ST_RD_ISSUE : msrb_pkg::ST_IDLE;
        end
      end
      default: state_next = msrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      msrb_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      msrb_pkg::ST_EXEC:     cmd.exec     = 1'b1;
      msrb_pkg::ST_RD_ISSUE: cmd.rd_issue = 1'b1;
      msrb_pkg::ST_RD_LOAD:  cmd.rd_load  = 1'b1;
      msrb_pkg::ST_WAIT:     ;
      default:               ;
    endcase
  end

  // memory data is only picked up in the cycle after its read was started
  a_load_after_issue: assert property (@(posedge clk) disable iff (rst)
    state == msrb_pkg::ST_RD_LOAD |-> $past(state) == msrb_pkg::ST_RD_ISSUE)
    else $error("byte load without a preceding memory read");

  // a read step is only started while bytes of the run remain
  a_issue_has_bytes: assert property (@(posedge clk) disable iff (rst)
    state == msrb_pkg::ST_RD_ISSUE |-> sts.remaining_nz)
    else $error("memory read started with no bytes left in the run");

endmodule : msrb_ctrl
`default_nettype wire

FILE: src/msrb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msrb_dp - ring buffer datapath
// Slot registers, ring pointers, lost counters, ring memory and result register.
// ----------------------------------------------------------------------------
module msrb_dp #(
  parameter int SLOTS    = msrb_pkg::DEF_SLOTS,
  parameter int CAPACITY = msrb_pkg::DEF_CAPACITY,
  parameter int MAX_READ = msrb_pkg::DEF_MAX_READ
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire msrb_pkg::ctrl_cmd_t                 cmd,
  output      msrb_pkg::dp_status_t                sts,
  input  wire logic [msrb_pkg::OPC_W-1:0]          in_opcode,
  input  wire logic [msrb_pkg::BUS_W-1:0]          in_bus,
  input  wire logic [msrb_pkg::BYTE_W-1:0]         in_data,
  input  wire logic [msrb_pkg::CNT_W-1:0]          in_count,
  input  wire logic                                cfg_write,
  input  wire logic [msrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [msrb_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                out_stall,
  output      logic                                out_valid,
  output      logic [msrb_pkg::BYTE_W-1:0]         data_out,
  output      logic                                data_valid,
  output      logic                                last,
  output      logic [msrb_pkg::FILL_OUT_W-1:0]     fill_count,
  output      logic [msrb_pkg::LOST_W-1:0]         lost_count,
  output      logic [msrb_pkg::STAT_W-1:0]         status
);

  localparam int PTR_W  = $clog2(CAPACITY);
  localparam int FILL_W = PTR_W + 1;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W = SLOT_W + PTR_W;
  localparam int CNT_W  = msrb_pkg::CNT_W;
  localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [FILL_W-1:0] CAP_F    = FILL_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  MAX_RD   = CNT_W'(MAX_READ);

  logic [msrb_pkg::CFG_W-1:0]  slot_bus [SLOTS];
  logic [PTR_W-1:0]            wptr     [SLOTS];
  logic [PTR_W-1:0]            rptr     [SLOTS];
  logic [msrb_pkg::LOST_W-1:0] dropped  [SLOTS];

  // item registers
  logic [msrb_pkg::OPC_W-1:0]  op_q;
  logic [msrb_pkg::BYTE_W-1:0] data_q;
  logic [CNT_W-1:0]            count_q;
  logic                        hit_q;
  logic [SLOT_W-1:0]           slot_q;

  logic [CNT_W-1:0]            remaining;
  logic [msrb_pkg::LOST_W-1:0] lost_hold;

  logic                        hit_lk;
  logic [SLOT_W-1:0]           slot_lk;
  logic [PTR_W-1:0]            w_sel, r_sel, w_inc, r_inc;
  logic [FILL_W-1:0]           fill_sel;
  logic [msrb_pkg::LOST_W-1:0] drop_sel;
  logic                        full;
  logic [CNT_W-1:0]            n_run;
  logic                        op_known;
  logic                        load_single;
  logic                        ram_we;
  logic [msrb_pkg::BYTE_W-1:0] ram_rdata;

  // bus lookup at capture, lowest slot wins
  always_comb begin
    hit_lk  = 1'b0;
    slot_lk = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_bus[i][msrb_pkg::CFG_W-1] &&
          slot_bus[i][msrb_pkg::BUS_W-1:0] == in_bus) begin
        hit_lk  = 1'b1;
        slot_lk = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= in_opcode;
      data_q  <= in_data;
      count_q <= (in_count > MAX_RD) ? MAX_RD : in_count;
      hit_q   <= hit_lk;
      slot_q  <= slot_lk;
    end
  end

  assign w_sel    = wptr[slot_q];
  assign r_sel    = rptr[slot_q];
  assign drop_sel = dropped[slot_q];
  assign w_inc    = (w_sel == PTR_LAST) ? '0 : w_sel + 1'b1;
  assign r_inc    = (r_sel == PTR_LAST) ? '0 : r_sel + 1'b1;
  assign full     = (w_inc == r_sel);
  assign fill_sel = {1'b0, w_sel} - {1'b0, r_sel} + ((w_sel < r_sel) ? CAP_F : '0);
  assign n_run    = (CMP_W'(fill_sel) < CMP_W'(count_q)) ? CNT_W'(fill_sel) : count_q;

  assign op_known = (op_q == msrb_pkg::OP_PUSH) || (op_q == msrb_pkg::OP_READ) ||
                    (op_q == msrb_pkg::OP_QUERY);

  assign sts.drop_item    = !op_known;
  assign sts.read_run     = (op_q == msrb_pkg::OP_READ) && hit_q && (n_run != '0);
  assign sts.remaining_nz = (remaining != '0);
  assign sts.out_taken    = out_valid && !out_stall;

  assign load_single = cmd.exec && op_known && !sts.read_run;
  assign ram_we      = cmd.exec && hit_q && (op_q == msrb_pkg::OP_PUSH) && !full;

  // per-slot state: slot binding, pointers, lost counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_bus[i] <= msrb_pkg::BUS_FREE;
        wptr[i]     <= '0;
        rptr[i]     <= '0;
        dropped[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd.exec && hit_q && slot_q == SLOT_W'(i)) begin
          case (op_q)
            msrb_pkg::OP_PUSH: begin
              if (full) begin
                if (dropped[i] != '1) dropped[i] <= dropped[i] + 1'b1;
              end else begin
                wptr[i] <= w_inc;
              end
            end
            msrb_pkg::OP_READ: dropped[i] <= '0;
            default: ;
          endcase
        end
        if (cmd.rd_load && slot_q == SLOT_W'(i)) begin
          rptr[i] <= r_inc;
        end
        if (cfg_write && i < msrb_pkg::NUM_CFG_REGS && int'(cfg_index) == i) begin
          slot_bus[i] <= cfg_data;
          wptr[i]     <= '0;
          rptr[i]     <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.exec) begin
      remaining <= sts.read_run ? n_run : '0;
    end else if (cmd.rd_load) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) lost_hold <= drop_sel;
  end

  msrb_ram #(
    .WIDTH (msrb_pkg::BYTE_W),
    .DEPTH (1 << ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({slot_q, w_sel}),
    .wdata (data_q),
    .re    (cmd.rd_issue),
    .raddr ({slot_q, r_sel}),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_single || cmd.rd_load) begin
      out_valid <= 1'b1;
    end else if (sts.out_taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_single) begin
      data_out   <= '0;
      data_valid <= 1'b0;
      last       <= 1'b1;
      fill_count <= '0;
      lost_count <= '0;
      status     <= msrb_pkg::STAT_OK;
      if (!hit_q) begin
        status <= msrb_pkg::STAT_NO_SLOT;
      end else begin
        case (op_q)
          msrb_pkg::OP_PUSH: begin
            fill_count <= msrb_pkg::FILL_OUT_W'(full ? fill_sel : fill_sel + 1'b1);
            status     <= full ? msrb_pkg::STAT_DROPPED : msrb_pkg::STAT_OK;
          end
          msrb_pkg::OP_READ: begin
            fill_count <= msrb_pkg::FILL_OUT_W'(fill_sel);
            lost_count <= drop_sel;
          end
          default: fill_count <= msrb_pkg::FILL_OUT_W'(fill_sel);
        endcase
      end
    end else if (cmd.rd_load) begin
      data_out   <= ram_rdata;
      data_valid <= 1'b1;
      last       <= (remaining == CNT_W'(1));
      fill_count <= msrb_pkg::FILL_OUT_W'(fill_sel - 1'b1);
      lost_count <= (remaining == CNT_W'(1)) ? lost_hold : '0;
      status     <= msrb_pkg::STAT_OK;
    end
  end

  // an unmatched bus gives a bare status beat
  a_no_slot_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == msrb_pkg::STAT_NO_SLOT |->
      last && !data_valid && fill_count == '0 && lost_count == '0)
    else $error("no-slot result carries data");

  // lost count is only reported at the end of a run
  a_lost_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> lost_count == '0 && data_valid)
    else $error("lost count on a beat that is not the last");

  // the read pointer moves only while a read run is in flight
  a_rptr_moves_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_load |-> $past(cmd.rd_issue) && remaining != '0)
    else $error("read pointer advanced outside a read run");

endmodule : msrb_dp
`default_nettype wire

FILE: src/multi_slot_rx_ring_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_rx_ring_buffer - per-slot receive rings bound to bus numbers
// Push stores a byte, read drains up to a count of bytes, query gives fill.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall, one beat per item (opcode, bus,
//     data_in, read_count); a beat is taken when in_valid is high and
//     in_stall is low
//   output channel: out_valid / out_stall, one beat per result; push, query,
//     an unmatched bus and an empty read give one beat, a read gives one beat
//     per drained byte with last on the final one; opcode 3 gives nothing
//   config port: cfg_write with cfg_index / cfg_data binds a slot to a bus
//     and empties that slot's ring; write only while the block is idle
//   timing: items are handled one at a time; a single-result item is
//     captured into the item registers, executed, and its beat loaded into
//     the result register, and the block is ready again in the cycle after
//     that beat is taken
//   a read runs each byte through a memory read, a load into the output
//     register and the output handshake
//   reset (rst, synchronous): all slots free, pointers and lost counters
//     zero; the ring memory itself is not cleared, no sweep needed
//   output stall: the result register holds its beat and the sequencer waits;
//     in_stall stays high until the item's last beat is taken
// ----------------------------------------------------------------------------
module multi_slot_rx_ring_buffer #(
  parameter int SLOTS    = msrb_pkg::DEF_SLOTS,
  parameter int CAPACITY = msrb_pkg::DEF_CAPACITY,
  parameter int MAX_READ = msrb_pkg::DEF_MAX_READ
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_write,
  input  wire logic [msrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msrb_pkg::CFG_W-1:0]      cfg_data,
  // item channel
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [msrb_pkg::OPC_W-1:0]      opcode,
  input  wire logic [msrb_pkg::BUS_W-1:0]      bus,
  input  wire logic [msrb_pkg::BYTE_W-1:0]     data_in,
  input  wire logic [msrb_pkg::CNT_W-1:0]      read_count,
  // result channel
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [msrb_pkg::BYTE_W-1:0]     data_out,
  output      logic                            data_valid,
  output      logic                            last,
  output      logic [msrb_pkg::FILL_OUT_W-1:0] fill_count,
  output      logic [msrb_pkg::LOST_W-1:0]     lost_count,
  output      logic [msrb_pkg::STAT_W-1:0]     status
);

  // command and status bundles between sequencer and datapath
  msrb_pkg::ctrl_cmd_t  cmd;
  msrb_pkg::dp_status_t sts;

  // sequencer: accept, execute, per-byte read steps, wait for beat taken
  msrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // datapath: slot lookup, pointers, lost counters, ring memory, result reg
  msrb_dp #(
    .SLOTS    (SLOTS),
    .CAPACITY (CAPACITY),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_opcode  (opcode),
    .in_bus     (bus),
    .in_data    (data_in),
    .in_count   (read_count),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .data_out   (data_out),
    .data_valid (data_valid),
    .last       (last),
    .fill_count (fill_count),
    .lost_count (lost_count),
    .status     (status)
  );

endmodule : multi_slot_rx_ring_buffer
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench - self-checking bench for multi_slot_rx_ring_buffer
// Drives push, read and query beats plus slot bindings, predicts every result
// beat with a behavioral copy of the rings and compares all result fields.
// ----------------------------------------------------------------------------
module testbench;
  import msrb_pkg::*;

  localparam int SLOT_COUNT  = DEF_SLOTS;
  localparam int CAP         = DEF_CAPACITY;
  localparam int READ_MAX    = DEF_MAX_READ;
  localparam int IDLE_PCT    = 32;      // percent of cycles a side holds off
  localparam int SETTLE      = 8;       // cycles after the last beat
  localparam int CYCLE_LIMIT = 600000;

  // opcode the block has no meaning for, swallowed without a result
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]     rdata;
    logic                  has_data;
    logic                  is_last;
    logic [FILL_OUT_W-1:0] fill;
    logic [LOST_W-1:0]     lost;
    logic [STAT_W-1:0]     stat;
  } rx_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [OPC_W-1:0]      opcode;
  logic [BUS_W-1:0]      bus;
  logic [BYTE_W-1:0]     data_in;
  logic [CNT_W-1:0]      read_count;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     data_out;
  logic                  data_valid;
  logic                  last;
  logic [FILL_OUT_W-1:0] fill_count;
  logic [LOST_W-1:0]     lost_count;
  logic [STAT_W-1:0]     status;

  multi_slot_rx_ring_buffer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .bus        (bus),
    .data_in    (data_in),
    .read_count (read_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .data_valid (data_valid),
    .last       (last),
    .fill_count (fill_count),
    .lost_count (lost_count),
    .status     (status)
  );

  // shadow copy of the rings and the slot bindings
  logic [CFG_W-1:0]  slot_bus_q [SLOT_COUNT];
  logic [BYTE_W-1:0] ring_mem   [SLOT_COUNT][CAP];
  int unsigned       wr_ptr     [SLOT_COUNT];
  int unsigned       rd_ptr     [SLOT_COUNT];
  logic [LOST_W-1:0] dropped    [SLOT_COUNT];

  // result beats still owed by the block, oldest first
  rx_result_t pending_beats [$];

  bit idle_on = 1'b1;   // random hold-off on both channels
  int mismatches;
  int items_sent;
  int beats_checked;
  int drops_predicted;
  int cfg_writes;

  // free-running clock, period 2
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side back-pressure, changes on the falling edge only
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // hard stop if the block hangs or loses a beat
  initial begin
    #(2 * CYCLE_LIMIT);
    $display("timeout, %0d result beats still outstanding", pending_beats.size());
    $display("FAIL multi_slot_rx_ring_buffer");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("mismatch on %s at beat %0d: got 0x%0h, want 0x%0h",
               what, beats_checked, got, want);
    mismatches++;
  endtask

  // lowest slot bound to the bus wins; negative bindings never match
  function automatic int slot_for_bus(input logic [BUS_W-1:0] bus_no);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_bus_q[i] == {1'b0, bus_no})
        return i;
    return -1;
  endfunction

  function automatic int unsigned fill_level(input int s);
    return (wr_ptr[s] + CAP - rd_ptr[s]) % CAP;
  endfunction

  // works out the result beats of one accepted item and updates the shadow rings
  task automatic compute_ring_results(input logic [OPC_W-1:0] opc,
                                      input logic [BUS_W-1:0] bus_no,
                                      input logic [BYTE_W-1:0] data_byte,
                                      input logic [CNT_W-1:0] count);
    int          s;
    int unsigned avail;
    int unsigned n;
    logic [LOST_W-1:0] lost;
    rx_result_t  r;
    if (opc == OP_UNUSED)
      return;
    s = slot_for_bus(bus_no);
    r = '0;
    r.is_last = 1'b1;
    if (s < 0) begin
      r.stat = STAT_NO_SLOT;
      pending_beats.push_back(r);
      return;
    end
    case (opc)
      OP_PUSH: begin
        // one entry always stays free
        if ((wr_ptr[s] + 1) % CAP == rd_ptr[s]) begin
          if (dropped[s] != '1)
            dropped[s]++;
          r.stat = STAT_DROPPED;
          drops_predicted++;
        end else begin
          ring_mem[s][wr_ptr[s]] = data_byte;
          wr_ptr[s] = (wr_ptr[s] + 1) % CAP;
          r.stat = STAT_OK;
        end
        r.fill = FILL_OUT_W'(fill_level(s));
        pending_beats.push_back(r);
      end
      OP_QUERY: begin
        r.fill = FILL_OUT_W'(fill_level(s));
        pending_beats.push_back(r);
      end
      OP_READ: begin
        avail = fill_level(s);
        lost = dropped[s];
        dropped[s] = '0;
        n = (count > READ_MAX) ? READ_MAX : count;
        if (avail < n)
          n = avail;
        if (n == 0) begin
          // nothing to drain: one beat carrying the lost count
          r.fill = FILL_OUT_W'(avail);
          r.lost = lost;
          pending_beats.push_back(r);
        end else begin
          for (int k = 0; k < n; k++) begin
            r.rdata = ring_mem[s][rd_ptr[s]];
            r.has_data = 1'b1;
            rd_ptr[s] = (rd_ptr[s] + 1) % CAP;
            r.is_last = (k == n - 1);
            r.fill = FILL_OUT_W'(fill_level(s));
            r.lost = r.is_last ? lost : '0;
            pending_beats.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // one item beat: optional hold-off, then hold the payload until taken
  task automatic send_item(input logic [OPC_W-1:0] opc, input logic [BUS_W-1:0] bus_no,
                           input logic [BYTE_W-1:0] data_byte,
                           input logic [CNT_W-1:0] count);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= opc;
    bus        <= bus_no;
    data_in    <= data_byte;
    read_count <= count;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
    compute_ring_results(opc, bus_no, data_byte, count);
  endtask

  // stop sending and let every owed beat come back, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // binds a slot and empties its ring; lost counter is left alone
  task automatic write_slot_bus(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    slot_bus_q[idx] = value;
    wr_ptr[idx] = 0;
    rd_ptr[idx] = 0;
    cfg_writes++;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly a bound bus, now and then any bus
  function automatic logic [BUS_W-1:0] pick_bus();
    int s;
    s = int'($urandom_range(SLOT_COUNT - 1));
    if (slot_bus_q[s][CFG_W-1])
      s = SLOT_COUNT - 1 - s;
    if (slot_bus_q[s][CFG_W-1] || $urandom_range(9) == 0)
      return BUS_W'($urandom_range(7));
    return slot_bus_q[s][BUS_W-1:0];
  endfunction

  task automatic send_random_item();
    logic [OPC_W-1:0] opc;
    logic [BUS_W-1:0] bus_no;
    logic [CNT_W-1:0] count;
    int pick;
    pick = $urandom_range(99);
    bus_no = pick_bus();
    count = CNT_W'($urandom_range(1, READ_MAX));
    if (pick < 8) begin
      // noise: any opcode, any bus, any count
      opc = OPC_W'($urandom_range(3));
      bus_no = BUS_W'($urandom_range(7));
      count = CNT_W'($urandom_range(127));
    end else if (pick < 60) begin
      opc = OP_PUSH;
    end else if (pick < 85) begin
      opc = OP_READ;
      if ($urandom_range(9) == 0)
        count = CNT_W'($urandom_range(127));
    end else begin
      opc = OP_QUERY;
    end
    send_item(opc, bus_no, BYTE_W'($urandom_range(255)), count);
  endtask

  task automatic random_phase(input int n_items, input logic [CFG_W-1:0] bus0,
                              input logic [CFG_W-1:0] bus1);
    drain_results();
    write_slot_bus(REG_SLOT0_BUS, bus0);
    write_slot_bus(REG_SLOT1_BUS, bus1);
    repeat (n_items) begin
      // now and then the sender waits for the block to go quiet
      if ($urandom_range(99) < 2)
        drain_results();
      send_random_item();
    end
  endtask

  // every item lands on an unbound bus right after reset
  task automatic test_no_slot();
    send_item(OP_PUSH, 3'd0, 8'h12, 7'd1);
    send_item(OP_READ, 3'd7, 8'h00, 7'd127);
    send_item(OP_QUERY, 3'd3, 8'hff, 7'd0);
    send_item(OP_UNUSED, 3'd0, 8'h00, 7'd1);
  endtask

  // bus extremes, empty reads, count saturation, shared bus, negative binding
  task automatic test_slot_binding();
    drain_results();
    write_slot_bus(REG_SLOT0_BUS, 4'd7);
    write_slot_bus(REG_SLOT1_BUS, 4'd0);
    send_item(OP_PUSH, 3'd7, 8'h00, 7'd1);
    send_item(OP_PUSH, 3'd7, 8'hff, 7'd1);
    send_item(OP_PUSH, 3'd0, 8'ha5, 7'd1);
    send_item(OP_QUERY, 3'd7, 8'h00, 7'd1);
    send_item(OP_READ, 3'd7, 8'h00, 7'd0);     // zero count still reports
    send_item(OP_READ, 3'd7, 8'h00, 7'd127);   // count above the cap
    send_item(OP_READ, 3'd7, 8'h00, 7'd1);     // ring now empty
    send_item(OP_QUERY, 3'd0, 8'h00, 7'd1);
    send_item(OP_QUERY, 3'd4, 8'h00, 7'd1);
    send_item(OP_UNUSED, 3'd7, 8'h55, 7'd64);
    // both slots on bus 7: slot 0 keeps serving it
    drain_results();
    write_slot_bus(REG_SLOT1_BUS, 4'd7);
    send_item(OP_PUSH, 3'd7, 8'h5a, 7'd1);
    send_item(OP_PUSH, 3'd0, 8'h11, 7'd1);
    send_item(OP_QUERY, 3'd7, 8'h00, 7'd1);
    // most negative binding frees slot 0, bus 7 falls to the emptied slot 1
    drain_results();
    write_slot_bus(REG_SLOT0_BUS, 4'b1000);
    send_item(OP_QUERY, 3'd7, 8'h00, 7'd1);
    send_item(OP_PUSH, 3'd7, 8'h3c, 7'd1);
    send_item(OP_READ, 3'd7, 8'h00, 7'd64);
    send_item(OP_READ, 3'd7, 8'h00, 7'd64);
  endtask

  // fill a ring past full, check drops, lost reporting and pointer wrap
  task automatic test_ring_full();
    drain_results();
    write_slot_bus(REG_SLOT0_BUS, 4'd3);
    write_slot_bus(REG_SLOT1_BUS, 4'd5);
    send_item(OP_PUSH, 3'd5, BYTE_W'($urandom_range(255)), 7'd1);
    repeat (CAP + 1) send_item(OP_PUSH, 3'd3, BYTE_W'($urandom_range(255)), 7'd1);
    send_item(OP_QUERY, 3'd3, 8'h00, 7'd1);
    send_item(OP_READ, 3'd3, 8'h00, 7'd1);     // lost count on the last beat
    send_item(OP_READ, 3'd3, 8'h00, 7'd1);     // counter was cleared
    // write pointer wraps to the start of the store, the last push drops
    repeat (3) send_item(OP_PUSH, 3'd3, BYTE_W'($urandom_range(255)), 7'd1);
    send_item(OP_READ, 3'd5, 8'h00, 7'd64);
    // rebinding empties the ring but keeps the lost count
    drain_results();
    write_slot_bus(REG_SLOT0_BUS, 4'd3);
    send_item(OP_READ, 3'd3, 8'h00, 7'd10);
    repeat (3) send_item(OP_PUSH, 3'd3, BYTE_W'($urandom_range(255)), 7'd1);
    send_item(OP_READ, 3'd3, 8'h00, 7'd127);
  endtask

  task automatic test_random_traffic();
    idle_on = 1'b1;
    random_phase(10, 4'd0, 4'd7);
    random_phase(10, BUS_FREE, CFG_W'($urandom_range(7)));
    random_phase(10, CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)));
    // long stretch with no hold-off on either side, both slots on one bus
    idle_on = 1'b0;
    random_phase(20, 4'd2, 4'd2);
    idle_on = 1'b1;
    random_phase(10, CFG_W'($urandom_range(7)), CFG_W'($urandom_range(7)));
    random_phase(10, 4'b1000, 4'd6);
  endtask

  // compare each taken result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", 64'({data_out, status}), '0);
      end else begin
        want = pending_beats.pop_front();
        if (data_out !== want.rdata)
          report_mismatch("data_out", 64'(data_out), 64'(want.rdata));
        if (data_valid !== want.has_data)
          report_mismatch("data_valid", 64'(data_valid), 64'(want.has_data));
        if (last !== want.is_last)
          report_mismatch("last", 64'(last), 64'(want.is_last));
        if (fill_count !== want.fill)
          report_mismatch("fill_count", 64'(fill_count), 64'(want.fill));
        if (lost_count !== want.lost)
          report_mismatch("lost_count", 64'(lost_count), 64'(want.lost));
        if (status !== want.stat)
          report_mismatch("status", 64'(status), 64'(want.stat));
        beats_checked++;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_SLOT0_BUS;
    cfg_data   = BUS_FREE;
    in_valid   = 1'b0;
    opcode     = OP_PUSH;
    bus        = '0;
    data_in    = '0;
    read_count = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_bus_q[i] = BUS_FREE;
      wr_ptr[i] = 0;
      rd_ptr[i] = 0;
      dropped[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_no_slot();
    test_slot_binding();
    test_ring_full();
    test_random_traffic();
    drain_results();

    $display("ran %0d items, checked %0d result beats", items_sent, beats_checked);
    $display("saw %0d full-ring drops over %0d slot bindings", drops_predicted, cfg_writes);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("PASS multi_slot_rx_ring_buffer");
    end else begin
      $display("FAIL multi_slot_rx_ring_buffer");
    end
    $finish;
  end

endmodule : testbench
`default_nettype wire
